// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// ===== hw/rtl/prfs_pkg.sv =====
// Shared opcodes, constants and saturation helper of the ranking factor engine.
`timescale 1ns / 1ps
package prfs_pkg;
	localparam logic [1:0] OP_LDU  = 2'd0;
	localparam logic [1:0] OP_LDI  = 2'd1;
	localparam logic [1:0] OP_UPD  = 2'd2;
	localparam logic [1:0] OP_EVAL = 2'd3;

	localparam logic signed [47:0] ONE_Q24 = 48'sd16777216;
	localparam logic signed [47:0] MAX_S32 = 48'sd2147483647;
	localparam logic signed [47:0] MIN_S32 = -48'sd2147483648;
	localparam logic [24:0] REG_WEIGHT_RST = 25'd1677722;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		logic signed [31:0] r;
		if (x > MAX_S32) begin
			r = 32'sh7fffffff;
		end else if (x < MIN_S32) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction
endpackage

// ===== hw/rtl/pairwise_rank_factor_sgd.sv =====
// Top level of the pairwise ranking factor engine with SGD on the squared hinge loss.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Operations are taken one at a time through a single shared 34 by 33 bit multiplier
// and one read port into each of the user and item factor memories. An evaluate makes
// three memory reads, one multiply and one accumulate per component. An update that
// changes the factors adds three bit-serial divisions of lambda by the counts and
// then eight products and three writes per component, which go through the same
// multiplier and memory ports; an update with no error takes the steps of an evaluate.
// The next transfer is taken once the engine is idle, even while a result still waits.
module pairwise_rank_factor_sgd #(
	parameter int RANK      = 16,
	parameter int NUM_USERS = 1024,
	parameter int NUM_ITEMS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [24:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// user_id, first_item, second_item, elem_index, elem_value, rate,
	// user_count, item1_count, item2_count, zero fill
	input  logic [143:0] s_tdata,
	// opcode
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// margin, update_applied, misranked, zero fill
	output logic [39:0]  m_tdata
);
	import prfs_pkg::*;

	localparam int AWU = (NUM_USERS * RANK > 1) ? $clog2(NUM_USERS * RANK) : 1;
	localparam int AWI = (NUM_ITEMS * RANK > 1) ? $clog2(NUM_ITEMS * RANK) : 1;
	localparam int KW = (RANK > 1) ? $clog2(RANK) : 1;
	localparam int UREC = (2 ** 20 + NUM_USERS - 1) / NUM_USERS;
	localparam int IREC = (2 ** 20 + NUM_ITEMS - 1) / NUM_ITEMS;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_IDX  = 4'd1;
	localparam logic [3:0] ST_LOAD = 4'd2;
	localparam logic [3:0] ST_RD0  = 4'd3;
	localparam logic [3:0] ST_RD1  = 4'd4;
	localparam logic [3:0] ST_RD2  = 4'd5;
	localparam logic [3:0] ST_MUL  = 4'd6;
	localparam logic [3:0] ST_STO  = 4'd7;
	localparam logic [3:0] ST_POST = 4'd8;
	localparam logic [3:0] ST_DIV  = 4'd9;
	localparam logic [3:0] ST_DIR  = 4'd10;
	localparam logic [3:0] ST_WRA  = 4'd11;
	localparam logic [3:0] ST_WRB  = 4'd12;
	localparam logic [3:0] ST_FIN  = 4'd13;

	function automatic logic [9:0] reduce_id(input logic [9:0] x, input int n, input int rec);
		logic [30:0] prod;
		logic [10:0] q;
		logic [31:0] r;
		prod = 31'(x) * 31'(rec);
		q = prod[30:20];
		r = 32'(x) - 32'(q) * 32'(n);
		return r[9:0];
	endfunction

	logic [3:0]  state_q;
	logic [24:0] reg_weight_q;
	logic [1:0]  op_q;
	logic [9:0]  uid_raw_q, i1_raw_q, i2_raw_q;
	logic [9:0]  uid_q, i1_q, i2_q;
	logic [3:0]  ei_q;
	logic signed [31:0] ev_q;
	logic [24:0] step_q;
	logic [15:0] cnt_q [3];
	logic [KW-1:0] k_q;
	logic [2:0]  s_q;
	logic        upd_q;
	logic signed [31:0] u_q, a_q, b_q, d_q, du_q, da_q, db_q, na_q;
	logic signed [66:0] prod_q;
	logic signed [42:0] p_q [8];
	logic signed [47:0] sum_q;
	logic [32:0] e2_q;
	logic [15:0] rem_q [3];
	logic [24:0] quo_q [3];
	logic [24:0] dvd_q;
	logic [4:0]  dc_q;
	logic signed [31:0] margin_q;
	logic        appl_q, misr_q;
	logic        out_valid_q;
	logic [39:0] out_data_q;

	logic signed [31:0] user_mem [NUM_USERS * RANK];
	logic signed [31:0] item_mem [NUM_ITEMS * RANK];
	logic signed [31:0] u_rd, i_rd;
	logic u_re, u_we, i_re, i_we;
	logic [AWU-1:0] u_addr_k, u_addr_ld, u_waddr;
	logic [AWI-1:0] a_addr_k, b_addr_k, i_addr_ld, i_raddr, i_waddr;
	logic signed [31:0] u_wd, i_wd;

	logic ei_ok, k_last;
	logic signed [42:0] fs;
	logic signed [33:0] op_a;
	logic signed [32:0] op_b;
	logic [24:0] rr [3];
	logic [16:0] trial [3];
	logic signed [31:0] du_n, da_n, db_n, nu, na, xb, nb, d_n;
	logic signed [47:0] err, emin;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	assign ei_ok = (32'(ei_q) < RANK);
	assign k_last = (k_q == KW'(RANK - 1));
	assign u_addr_k = AWU'(32'(uid_q) * 32'(RANK) + 32'(k_q));
	assign u_addr_ld = AWU'(32'(uid_q) * 32'(RANK) + 32'(ei_q));
	assign a_addr_k = AWI'(32'(i1_q) * 32'(RANK) + 32'(k_q));
	assign b_addr_k = AWI'(32'(i2_q) * 32'(RANK) + 32'(k_q));
	assign i_addr_ld = AWI'(32'(i1_q) * 32'(RANK) + 32'(ei_q));

	assign fs = $signed(prod_q[66:24]);
	assign du_n = sat32(48'(p_q[1]) - 48'(p_q[0]));
	assign da_n = sat32(48'(p_q[3]) - 48'(p_q[2]));
	assign db_n = sat32(48'(p_q[2]) + 48'(p_q[4]));
	assign nu = sat32(48'(u_q) - 48'(p_q[5]));
	assign na = sat32(48'(a_q) - 48'(p_q[6]));
	assign xb = (i1_q == i2_q) ? na_q : b_q;
	assign nb = sat32(48'(xb) - 48'(p_q[7]));
	assign d_n = sat32(48'(a_q) - 48'(i_rd));
	assign err = ONE_Q24 - sum_q;
	assign emin = (err > MAX_S32) ? MAX_S32 : err;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			rr[j] = (cnt_q[j] == 16'd0) ? 25'd0 : quo_q[j];
			trial[j] = {rem_q[j], dvd_q[24]};
		end
	end

	always_comb begin
		op_a = 34'(u_q);
		op_b = 33'(d_q);
		if (upd_q) begin
			unique case (s_q)
				3'd0: begin op_a = $signed({1'b0, e2_q}); op_b = 33'(d_q); end
				3'd1: begin op_a = $signed({9'd0, rr[0]}); op_b = 33'(u_q); end
				3'd2: begin op_a = $signed({1'b0, e2_q}); op_b = 33'(u_q); end
				3'd3: begin op_a = $signed({9'd0, rr[1]}); op_b = 33'(a_q); end
				3'd4: begin op_a = $signed({9'd0, rr[2]}); op_b = 33'(b_q); end
				3'd5: begin op_a = $signed({9'd0, step_q}); op_b = 33'(du_q); end
				3'd6: begin op_a = $signed({9'd0, step_q}); op_b = 33'(da_q); end
				default: begin op_a = $signed({9'd0, step_q}); op_b = 33'(db_q); end
			endcase
		end
	end

	always_comb begin
		u_re = (state_q == ST_RD0);
		u_we = ((state_q == ST_LOAD) && (op_q == OP_LDU) && ei_ok) || (state_q == ST_WRA);
		u_waddr = (state_q == ST_LOAD) ? u_addr_ld : u_addr_k;
		u_wd = (state_q == ST_LOAD) ? ev_q : nu;
		i_re = (state_q == ST_RD0) || (state_q == ST_RD1);
		i_raddr = (state_q == ST_RD0) ? a_addr_k : b_addr_k;
		i_we = ((state_q == ST_LOAD) && (op_q == OP_LDI) && ei_ok) || (state_q == ST_WRA)
			|| (state_q == ST_WRB);
		if (state_q == ST_LOAD) begin
			i_waddr = i_addr_ld;
			i_wd = ev_q;
		end else if (state_q == ST_WRA) begin
			i_waddr = a_addr_k;
			i_wd = na;
		end else begin
			i_waddr = b_addr_k;
			i_wd = nb;
		end
	end

	always_ff @(posedge clk) begin
		if (u_we) begin
			user_mem[u_waddr] <= u_wd;
		end
		if (u_re) begin
			u_rd <= user_mem[u_addr_k];
		end
	end

	always_ff @(posedge clk) begin
		if (i_we) begin
			item_mem[i_waddr] <= i_wd;
		end
		if (i_re) begin
			i_rd <= item_mem[i_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_weight_q <= REG_WEIGHT_RST;
		end else if (cfg_we) begin
			reg_weight_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op_q <= s_tuser;
					uid_raw_q <= s_tdata[9:0];
					i1_raw_q <= s_tdata[19:10];
					i2_raw_q <= s_tdata[29:20];
					ei_q <= s_tdata[33:30];
					ev_q <= $signed(s_tdata[65:34]);
					step_q <= s_tdata[90:66];
					cnt_q[0] <= s_tdata[106:91];
					cnt_q[1] <= s_tdata[122:107];
					cnt_q[2] <= s_tdata[138:123];
				end
			end
			ST_IDX: begin
				uid_q <= reduce_id(uid_raw_q, NUM_USERS, UREC);
				i1_q <= reduce_id(i1_raw_q, NUM_ITEMS, IREC);
				i2_q <= reduce_id(i2_raw_q, NUM_ITEMS, IREC);
				sum_q <= '0;
			end
			ST_LOAD: begin
				margin_q <= '0;
				appl_q <= 1'b0;
				misr_q <= 1'b0;
			end
			ST_RD1: begin
				u_q <= u_rd;
				a_q <= i_rd;
			end
			ST_RD2: begin
				b_q <= i_rd;
				d_q <= d_n;
			end
			ST_MUL: begin
				prod_q <= op_a * op_b;
			end
			ST_STO: begin
				if (upd_q) begin
					p_q[s_q] <= fs;
				end else begin
					sum_q <= sum_q + 48'(fs);
				end
			end
			ST_POST: begin
				margin_q <= sat32(sum_q);
				misr_q <= (op_q == OP_EVAL) && (sum_q <= 48'sd0);
				appl_q <= 1'b0;
				e2_q <= {emin[31:0], 1'b0};
				dvd_q <= reg_weight_q;
				for (int j = 0; j < 3; j++) begin
					rem_q[j] <= '0;
				end
			end
			ST_DIV: begin
				for (int j = 0; j < 3; j++) begin
					if (trial[j] >= {1'b0, cnt_q[j]}) begin
						rem_q[j] <= 16'(trial[j] - {1'b0, cnt_q[j]});
						quo_q[j] <= {quo_q[j][23:0], 1'b1};
					end else begin
						rem_q[j] <= trial[j][15:0];
						quo_q[j] <= {quo_q[j][23:0], 1'b0};
					end
				end
				dvd_q <= {dvd_q[23:0], 1'b0};
				appl_q <= 1'b1;
			end
			ST_DIR: begin
				du_q <= du_n;
				da_q <= da_n;
				db_q <= db_n;
			end
			ST_WRA: begin
				na_q <= na;
			end
			ST_FIN: begin
				if (!out_valid_q || m_tready) begin
					out_data_q <= {6'd0, misr_q, appl_q, margin_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			s_q <= '0;
			upd_q <= 1'b0;
			dc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_IDX;
					end
				end
				ST_IDX: begin
					k_q <= '0;
					upd_q <= 1'b0;
					if ((op_q == OP_LDU) || (op_q == OP_LDI)) begin
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_RD0;
					end
				end
				ST_LOAD: state_q <= ST_FIN;
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: begin
					s_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_STO;
				ST_STO: begin
					if (upd_q) begin
						s_q <= s_q + 3'd1;
						if (s_q == 3'd4) begin
							state_q <= ST_DIR;
						end else if (s_q == 3'd7) begin
							state_q <= ST_WRA;
						end else begin
							state_q <= ST_MUL;
						end
					end else if (k_last) begin
						state_q <= ST_POST;
					end else begin
						k_q <= k_q + KW'(1);
						state_q <= ST_RD0;
					end
				end
				ST_POST: begin
					dc_q <= '0;
					if ((op_q == OP_UPD) && (err > 48'sd0)) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					dc_q <= dc_q + 5'd1;
					if (dc_q == 5'd24) begin
						k_q <= '0;
						upd_q <= 1'b1;
						state_q <= ST_RD0;
					end
				end
				ST_DIR: state_q <= ST_MUL;
				ST_WRA: state_q <= ST_WRB;
				ST_WRB: begin
					if (k_last) begin
						state_q <= ST_FIN;
					end else begin
						k_q <= k_q + KW'(1);
						state_q <= ST_RD0;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_NEXT(a_accept_to_idx, clk, arst_n, s_tvalid && s_tready, state_q == ST_IDX)
	`ASSERT_SAME(a_write_only_update, clk, arst_n, (state_q == ST_WRA) || (state_q == ST_DIV), (op_q == OP_UPD) && (err > 48'sd0 || state_q == ST_WRA))
	`ASSERT_SAME(a_k_in_range, clk, arst_n, state_q == ST_RD0, 32'(k_q) < RANK)
	`ASSERT_NEXT(a_fin_delivers, clk, arst_n, (state_q == ST_FIN) && (!out_valid_q || m_tready), out_valid_q && (state_q == ST_IDLE))

endmodule

// ===== tb/sv/prfs_checker.sv =====
// Transfer monitor, factor-update predictor and result comparator for the ranking factor engine.
`timescale 1ns / 1ps
module prfs_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [24:0]  cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [143:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [39:0]  m_tdata,
	output int           errors,
	output int           pending
);
	import prfs_pkg::*;

	typedef struct packed {
		logic signed [31:0] margin;
		logic               applied;
		logic               misranked;
	} rank_result_t;

	localparam int RANK = 16;

	logic signed [31:0] user_fac [0:1024*RANK-1];
	logic signed [31:0] item_vec [0:1024*RANK-1];
	logic [24:0] lambda_q24;
	rank_result_t expected_results[$];

	function automatic longint clip32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint lambda_share(longint cnt);
		if (cnt == 0) return 0;
		return longint'(lambda_q24) / cnt;
	endfunction

	function automatic logic signed [31:0] step_down(longint x, longint rate, longint dir);
		longint r;
		r = clip32(x - ((rate * dir) >>> 24));
		return r[31:0];
	endfunction

	task automatic predict_op(input logic [1:0] op, input logic [143:0] d);
		int uid, i1, i2, ei, k;
		longint ev, rate, sum, err, e2, ru, r1, r2, uo, ao, bo, dif, gu, du, da, db;
		rank_result_t res;
		uid  = d[9:0];
		i1   = d[19:10];
		i2   = d[29:20];
		ei   = d[33:30];
		ev   = longint'($signed(d[65:34]));
		rate = longint'(d[90:66]);
		res  = '0;
		if (op == OP_LDU || op == OP_LDI) begin
			if (ei < RANK) begin
				if (op == OP_LDU) user_fac[uid*RANK+ei] = ev[31:0];
				else item_vec[i1*RANK+ei] = ev[31:0];
			end
		end else begin
			sum = 0;
			for (k = 0; k < RANK; k++) begin
				dif = clip32(longint'(item_vec[i1*RANK+k]) - longint'(item_vec[i2*RANK+k]));
				sum += (longint'(user_fac[uid*RANK+k]) * dif) >>> 24;
			end
			res.margin = clip32(sum);
			if (op == OP_EVAL) begin
				res.misranked = (sum <= 0);
			end else begin
				err = 64'sd16777216 - sum;
				if (err > 0) begin
					e2 = 2 * ((err > 64'sd2147483647) ? 64'sd2147483647 : err);
					ru = lambda_share(longint'(d[106:91]));
					r1 = lambda_share(longint'(d[122:107]));
					r2 = lambda_share(longint'(d[138:123]));
					res.applied = 1'b1;
					for (k = 0; k < RANK; k++) begin
						uo  = user_fac[uid*RANK+k];
						ao  = item_vec[i1*RANK+k];
						bo  = item_vec[i2*RANK+k];
						dif = clip32(ao - bo);
						gu  = (e2 * uo) >>> 24;
						du  = clip32(-((e2 * dif) >>> 24) + ((ru * uo) >>> 24));
						da  = clip32(-gu + ((r1 * ao) >>> 24));
						db  = clip32(gu + ((r2 * bo) >>> 24));
						user_fac[uid*RANK+k] = step_down(uo, rate, du);
						item_vec[i1*RANK+k]  = step_down(ao, rate, da);
						item_vec[i2*RANK+k]  = step_down(longint'(item_vec[i2*RANK+k]), rate, db);
					end
				end
			end
		end
		expected_results = {expected_results, res};
	endtask

	always @(posedge clk or negedge arst_n) begin
		rank_result_t want, got;
		if (!arst_n) begin
			lambda_q24 = REG_WEIGHT_RST;
			errors = 0;
			pending = 0;
			expected_results.delete();
		end else begin
			if (cfg_we) lambda_q24 = cfg_wdata;
			if (s_tvalid && s_tready) predict_op(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				got.margin    = m_tdata[31:0];
				got.applied   = m_tdata[32];
				got.misranked = m_tdata[33];
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t unexpected result %h", $time, m_tdata);
				end else begin
					want = expected_results.pop_front();
					if (got.margin !== want.margin) begin
						errors++;
						$display("%0t margin expected %h actual %h", $time,
							want.margin, got.margin);
					end
					if (got.applied !== want.applied) begin
						errors++;
						$display("%0t update_applied expected %b actual %b", $time,
							want.applied, got.applied);
					end
					if (got.misranked !== want.misranked) begin
						errors++;
						$display("%0t misranked expected %b actual %b", $time,
							want.misranked, got.misranked);
					end
				end
			end
			pending = expected_results.size();
		end
	end
endmodule

// ===== tb/sv/tb_pairwise_rank_factor_sgd.sv =====
// Stimulus, flow control and verdict for the ranking factor engine testbench.
`timescale 1ns / 1ps
module tb_pairwise_rank_factor_sgd;
	import prfs_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [24:0]  cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [143:0] s_tdata = '0;
	logic [1:0]   s_tuser = OP_LDU;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [39:0]  m_tdata;
	int           errors, pending;
	bit           idle_on = 1'b1;
	bit           hold_req = 1'b0;
	longint       cycles = 0;

	int user_pool[4] = '{0, 1023, 5, 600};
	int item_pool[5] = '{0, 1023, 7, 300, 514};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	pairwise_rank_factor_sgd i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	prfs_checker i_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > 4000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic logic [31:0] factor_value();
		case ($urandom_range(11))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			default: return $urandom_range(0, 67108864) - 33554432;
		endcase
	endfunction

	function automatic logic [24:0] learn_rate();
		case ($urandom_range(15))
			0: return 25'd0;
			1: return 25'd16777216;
			2: return 25'($urandom_range(0, 16777216));
			default: return 25'($urandom_range(0, 1 << 20));
		endcase
	endfunction

	function automatic logic [15:0] pair_count();
		case ($urandom_range(7))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'($urandom_range(1, 8));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic push_op(input logic [1:0] op, input int uid, input int i1, input int i2,
			input int ei, input logic [31:0] ev, input logic [24:0] rate,
			input logic [15:0] cu, input logic [15:0] c1, input logic [15:0] c2);
		if (idle_on && $urandom_range(3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'd0, c2, c1, cu, rate, ev, 4'(ei), 10'(i2), 10'(i1), 10'(uid)};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic random_op();
		int uid, i1, i2, sel;
		uid = user_pool[$urandom_range(3)];
		i1  = item_pool[$urandom_range(4)];
		i2  = ($urandom_range(9) == 0) ? i1 : item_pool[$urandom_range(4)];
		sel = $urandom_range(99);
		if (sel < 15)
			push_op(OP_LDU, ($urandom_range(3) == 0) ? $urandom_range(1023) : uid, 0, 0,
				$urandom_range(15), factor_value(), 25'($urandom()), 16'($urandom()),
				16'($urandom()), 16'($urandom()));
		else if (sel < 30)
			push_op(OP_LDI, $urandom_range(1023),
				($urandom_range(3) == 0) ? $urandom_range(1023) : i1, $urandom_range(1023),
				$urandom_range(15), factor_value(), 25'($urandom()), 16'($urandom()),
				16'($urandom()), 16'($urandom()));
		else if (sel < 75)
			push_op(OP_UPD, uid, i1, i2, $urandom_range(15), $urandom(), learn_rate(),
				pair_count(), pair_count(), pair_count());
		else
			push_op(OP_EVAL, uid, i1, i2, $urandom_range(15), $urandom(), 25'($urandom()),
				16'($urandom()), 16'($urandom()), 16'($urandom()));
	endtask

	task automatic settle_and_write(input logic [24:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int k, n, ph;
		logic [24:0] lambda_steps[4];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every factor vector in the pools is written before it is read.
		foreach (user_pool[n])
			for (k = 0; k < 16; k++)
				push_op(OP_LDU, user_pool[n], 0, 0, k, factor_value(), 0, 0, 0, 0);
		foreach (item_pool[n])
			for (k = 0; k < 16; k++)
				push_op(OP_LDI, 0, item_pool[n], 0, k, factor_value(), 0, 0, 0, 0);

		push_op(OP_EVAL, 0, 7, 7, 0, 0, 0, 0, 0, 0);
		push_op(OP_UPD, 1023, 0, 1023, 0, 0, 25'd16777216, 0, 0, 0);
		push_op(OP_UPD, 5, 300, 300, 0, 0, 25'd1048576, 16'hffff, 1, 16'hffff);
		push_op(OP_UPD, 600, 514, 7, 0, 0, 25'd0, 1, 1, 1);
		push_op(OP_EVAL, 1023, 1023, 0, 0, 0, 0, 0, 0, 0);
		push_op(OP_LDU, 1023, 0, 0, 15, 32'h7fff_ffff, 0, 0, 0, 0);
		push_op(OP_LDI, 0, 1023, 0, 15, 32'h8000_0000, 0, 0, 0, 0);
		push_op(OP_UPD, 1023, 1023, 0, 0, 0, 25'd16777216, 0, 0, 0);
		push_op(OP_UPD, 1023, 0, 1023, 0, 0, 25'd16777216, 16'hffff, 16'hffff, 16'hffff);
		push_op(OP_EVAL, 5, 0, 514, 0, 0, 0, 0, 0, 0);

		lambda_steps = '{25'd0, 25'd16777216, 25'd0, 25'd1677722};
		lambda_steps[2] = 25'($urandom_range(0, 16777216));
		for (ph = 0; ph < 5; ph++) begin
			if (ph > 0) settle_and_write(lambda_steps[ph-1]);
			for (n = 0; n < 95; n++) begin
				if (ph == 1 && n == 20) hold_req = 1'b1;
				if (ph == 4 && n == 30) idle_on = 1'b0;
				random_op();
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== pairwise_rank_factor_sgd.f =====
+incdir+hw/rtl
hw/rtl/prfs_pkg.sv
hw/rtl/pairwise_rank_factor_sgd.sv
tb/sv/prfs_checker.sv
tb/sv/tb_pairwise_rank_factor_sgd.sv
